// ===== rtl/vjc_pkg.sv =====
// Shared types and constants for the value-to-jet-color mapper.
package vjc_pkg;

    localparam int VALUE_BITS = 32;
    localparam int Q_BITS     = 10;
    localparam int DIV_STEPS  = 2;
    localparam int CFG_IDX_BITS = 3;

    localparam logic [CFG_IDX_BITS-1:0] REG_KNOWN_MASK = 3'd6;

    localparam logic signed [VALUE_BITS-1:0] LOW_RESET  = -32'sd65536;
    localparam logic signed [VALUE_BITS-1:0] HIGH_RESET = 32'sd65536;

    typedef struct packed {
        logic [1:0]                    quantity_index;
        logic signed [VALUE_BITS-1:0]  sample_value;
    } in_item_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       color_valid;
    } out_item_t;

    typedef struct packed {
        logic ok;
        logic sat_red;
        logic sat_blue;
    } ctrl_t;

endpackage

// ===== rtl/vjc_div_pipe.sv =====
// Pipelined restoring divider: fraction bits of rem/div, DIV_STEPS (two) bits per stage.
module vjc_div_pipe (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           advance,
    input  logic                           in_valid,
    input  vjc_pkg::ctrl_t                 in_ctrl,
    input  logic [vjc_pkg::VALUE_BITS-1:0] in_rem,
    input  logic [vjc_pkg::VALUE_BITS-1:0] in_div,
    output logic                           out_valid,
    output vjc_pkg::ctrl_t                 out_ctrl,
    output logic [vjc_pkg::Q_BITS-1:0]     out_quot
);
    localparam int W      = vjc_pkg::VALUE_BITS;
    localparam int QB     = vjc_pkg::Q_BITS;
    localparam int STEPS  = vjc_pkg::DIV_STEPS;
    localparam int STAGES = QB / STEPS;

    logic           valid_reg [STAGES];
    vjc_pkg::ctrl_t ctrl_reg  [STAGES];
    logic [W-1:0]   rem_reg   [STAGES];
    logic [W-1:0]   div_reg   [STAGES];
    logic [QB-1:0]  quot_reg  [STAGES];

    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        logic           valid_in;
        vjc_pkg::ctrl_t ctrl_in;
        logic [W-1:0]   rem_in;
        logic [W-1:0]   div_in;
        logic [QB-1:0]  quot_in;
        logic [W-1:0]   rem_next;
        logic [QB-1:0]  quot_next;
        logic [W:0]     shifted;
        logic [W:0]     diff;

        if (g == 0) begin : g_first
            assign valid_in = in_valid;
            assign ctrl_in  = in_ctrl;
            assign rem_in   = in_rem;
            assign div_in   = in_div;
            assign quot_in  = '0;
        end else begin : g_rest
            assign valid_in = valid_reg[g-1];
            assign ctrl_in  = ctrl_reg[g-1];
            assign rem_in   = rem_reg[g-1];
            assign div_in   = div_reg[g-1];
            assign quot_in  = quot_reg[g-1];
        end

        always_comb begin
            rem_next  = rem_in;
            quot_next = quot_in;
            shifted   = '0;
            diff      = '0;
            for (int k = 0; k < STEPS; k++) begin
                shifted = {rem_next, 1'b0};
                diff    = shifted - {1'b0, div_in};
                if (shifted >= {1'b0, div_in}) begin
                    rem_next  = diff[W-1:0];
                    quot_next = {quot_next[QB-2:0], 1'b1};
                end else begin
                    rem_next  = shifted[W-1:0];
                    quot_next = {quot_next[QB-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[g] <= 1'b0;
            end else if (advance) begin
                valid_reg[g] <= valid_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (advance) begin
                ctrl_reg[g] <= ctrl_in;
                rem_reg[g]  <= rem_next;
                div_reg[g]  <= div_in;
                quot_reg[g] <= quot_next;
            end
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_ctrl  = ctrl_reg[STAGES-1];
    assign out_quot  = quot_reg[STAGES-1];

endmodule

// ===== rtl/value_to_jet_color.sv =====
// Top level: maps a signed Q16.16 sample to a jet-ramp RGB color per quantity scale.
//
//  channel | ports                          | dir | moves
//  --------+--------------------------------+-----+-----------------------------
//  cfg     | cfg_valid/ready/index/data     | in  | scale bound or known mask write
//  s       | s_valid/ready/data             | in  | item: quantity index, sample
//  m       | m_valid/ready/data             | out | item: red, green, blue, valid
//
//  One item per cycle unless m stalls; stages in order: bound select and subtract, sign fix,
//  range check, five divider stages of two quotient bits each, color stage.
//  Reset is synchronous: pipeline empties, bounds go to -1.0/+1.0, mask clears.
//  A stall at m holds every stage in place; s_ready stays low while the stall lasts.
//  cfg_ready is always high.
module value_to_jet_color #(
    parameter int NUM_QUANTITIES = 3
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [vjc_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [vjc_pkg::VALUE_BITS-1:0]       cfg_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  vjc_pkg::in_item_t                    s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output vjc_pkg::out_item_t                   m_data
);
    localparam int W  = vjc_pkg::VALUE_BITS;
    localparam int QB = vjc_pkg::Q_BITS;
    localparam logic [1:0] SEG_RED_YELLOW  = 2'd0;
    localparam logic [1:0] SEG_YELLOW_GRN  = 2'd1;
    localparam logic [1:0] SEG_GRN_CYAN    = 2'd2;
    localparam logic [1:0] SEG_CYAN_BLUE   = 2'd3;

    logic signed [W-1:0]       lo_reg [NUM_QUANTITIES];
    logic signed [W-1:0]       hi_reg [NUM_QUANTITIES];
    logic [NUM_QUANTITIES-1:0] known_reg;

    logic advance;
    assign advance   = !m_valid || m_ready;
    assign s_ready   = advance;
    assign cfg_ready = 1'b1;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_QUANTITIES; i++) begin
                lo_reg[i] <= vjc_pkg::LOW_RESET;
                hi_reg[i] <= vjc_pkg::HIGH_RESET;
            end
            known_reg <= '0;
        end else if (cfg_valid) begin
            if (cfg_index == vjc_pkg::REG_KNOWN_MASK) begin
                known_reg <= cfg_data[NUM_QUANTITIES-1:0];
            end else begin
                for (int i = 0; i < NUM_QUANTITIES; i++) begin
                    if (cfg_index[2:1] == 2'(i)) begin
                        if (cfg_index[0]) begin
                            hi_reg[i] <= cfg_data;
                        end else begin
                            lo_reg[i] <= cfg_data;
                        end
                    end
                end
            end
        end
    end

    // stage 1: scale select, range and offset
    logic signed [W-1:0] lo_sel, hi_sel;
    logic                hit;
    logic signed [W:0]   lo_ext, hi_ext, v_ext, d1_next, n1_next;

    always_comb begin
        lo_sel = '0;
        hi_sel = '0;
        hit    = 1'b0;
        for (int i = 0; i < NUM_QUANTITIES; i++) begin
            if (s_data.quantity_index == 2'(i)) begin
                lo_sel = lo_reg[i];
                hi_sel = hi_reg[i];
                hit    = known_reg[i];
            end
        end
        lo_ext  = {lo_sel[W-1], lo_sel};
        hi_ext  = {hi_sel[W-1], hi_sel};
        v_ext   = {s_data.sample_value[W-1], s_data.sample_value};
        d1_next = hi_ext - lo_ext;
        n1_next = hi_ext - v_ext;
    end

    logic              v1_reg, known1_reg;
    logic signed [W:0] d1_reg, n1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (advance) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            known1_reg <= hit;
            d1_reg     <= d1_next;
            n1_reg     <= n1_next;
        end
    end

    // stage 2: make the range positive
    logic signed [W:0] d2_abs, n2_next;
    logic              v2_reg, ok2_reg;
    logic [W-1:0]      d2_reg;
    logic signed [W:0] n2_reg;

    always_comb begin
        if (d1_reg[W]) begin
            d2_abs  = -d1_reg;
            n2_next = -n1_reg;
        end else begin
            d2_abs  = d1_reg;
            n2_next = n1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (advance) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            ok2_reg <= known1_reg && (d1_reg != '0);
            d2_reg  <= d2_abs[W-1:0];
            n2_reg  <= n2_next;
        end
    end

    // stage 3: saturation checks
    vjc_pkg::ctrl_t ctrl3_next, ctrl3_reg;
    logic           v3_reg;
    logic [W-1:0]   rem3_reg, div3_reg;

    always_comb begin
        ctrl3_next.ok       = ok2_reg;
        ctrl3_next.sat_red  = n2_reg[W] || (n2_reg == '0);
        ctrl3_next.sat_blue = !ctrl3_next.sat_red && (n2_reg[W-1:0] >= d2_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (advance) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            ctrl3_reg <= ctrl3_next;
            rem3_reg  <= n2_reg[W-1:0];
            div3_reg  <= d2_reg;
        end
    end

    // ratio bits
    logic           vd;
    vjc_pkg::ctrl_t ctrld;
    logic [QB-1:0]  quot;

    vjc_div_pipe u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .in_valid  (v3_reg),
        .in_ctrl   (ctrl3_reg),
        .in_rem    (rem3_reg),
        .in_div    (div3_reg),
        .out_valid (vd),
        .out_ctrl  (ctrld),
        .out_quot  (quot)
    );

    // color stage
    vjc_pkg::out_item_t color_next, m_data_reg;
    logic               m_valid_reg;
    logic [7:0]         ramp;

    always_comb begin
        ramp       = quot[7:0];
        color_next = '0;
        if (ctrld.ok) begin
            color_next.color_valid = 1'b1;
            if (ctrld.sat_red) begin
                color_next.red = 8'd255;
            end else if (ctrld.sat_blue) begin
                color_next.blue = 8'd255;
            end else begin
                case (quot[QB-1:QB-2])
                    SEG_RED_YELLOW: begin
                        color_next.red   = 8'd255;
                        color_next.green = ramp;
                    end
                    SEG_YELLOW_GRN: begin
                        color_next.red   = 8'd255 - ramp;
                        color_next.green = 8'd255;
                    end
                    SEG_GRN_CYAN: begin
                        color_next.green = 8'd255;
                        color_next.blue  = ramp;
                    end
                    SEG_CYAN_BLUE: begin
                        color_next.green = 8'd255 - ramp;
                        color_next.blue  = 8'd255;
                    end
                    default: begin
                        color_next.red = 8'd0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= vd;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= color_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== test/tb_value_to_jet_color.sv =====
// Self-checking testbench for value_to_jet_color: scale registers, jet ramp and handshakes.
`timescale 1ns / 100ps

module tb_value_to_jet_color;

    localparam int CLK_PERIOD     = 8;
    localparam int NUM_QUANTITIES = 3;
    localparam int PIPE_LATENCY   = 9;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 60;
    localparam int PHASE_ITEMS    = 210;

    localparam logic [2:0] REG_LOW_Q0  = 3'd0;
    localparam logic [2:0] REG_HIGH_Q0 = 3'd1;
    localparam logic [2:0] REG_LOW_Q1  = 3'd2;
    localparam logic [2:0] REG_HIGH_Q1 = 3'd3;
    localparam logic [2:0] REG_LOW_Q2  = 3'd4;
    localparam logic [2:0] REG_HIGH_Q2 = 3'd5;
    localparam logic [2:0] REG_SPARE   = 3'd7;
    localparam int         REG_STRIDE  = 2;

    localparam longint VAL_MAX   = 64'sd2147483647;
    localparam longint VAL_MIN   = -VAL_MAX - 1;
    localparam longint ONE       = 64'sd65536;
    localparam longint Q_FULL    = 1024;
    localparam int     FRAC_BITS = 24;
    localparam longint FRAC_ONE  = 64'sd1 << FRAC_BITS;
    localparam logic [7:0] LEVEL_MAX = 8'd255;

    typedef enum logic [1:0] {
        SEG_RED_YELLOW,
        SEG_YELLOW_GREEN,
        SEG_GREEN_CYAN,
        SEG_CYAN_BLUE
    } ramp_seg_e;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [2:0]            cfg_index = '0;
    logic [31:0]           cfg_data = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    vjc_pkg::in_item_t     s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    vjc_pkg::out_item_t    m_data;

    // shadow of the scale registers, updated on each accepted write
    logic signed [31:0]    scale_low [NUM_QUANTITIES];
    logic signed [31:0]    scale_high [NUM_QUANTITIES];
    logic [2:0]            known_mask;

    vjc_pkg::in_item_t     pending_samples[$];
    vjc_pkg::out_item_t    expected_colors[$];
    vjc_pkg::out_item_t    want_color;

    int   send_idle_pct = 24;
    int   recv_idle_pct = 70;
    bit   hold_request = 1'b0;
    bit   hold_taken = 1'b0;
    int   hold_left = 0;
    bit   s_taken = 1'b0;
    int   stall_cycles = 0;
    int   fail_count = 0;

    value_to_jet_color dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic vjc_pkg::out_item_t predict_color(vjc_pkg::in_item_t item);
        vjc_pkg::out_item_t c;
        int                 qi;
        longint             span;
        longint             num;
        longint             q;
        logic [7:0]         ramp;
        c = '0;
        qi = item.quantity_index;
        if (qi < NUM_QUANTITIES && known_mask[qi]) begin
            span = longint'(scale_high[qi]) - longint'(scale_low[qi]);
            num  = longint'(scale_high[qi]) - longint'($signed(item.sample_value));
            if (span != 0) begin
                c.color_valid = 1'b1;
                if (span < 0) begin
                    span = -span;
                    num  = -num;
                end
                if (num <= 0) begin
                    c.red = LEVEL_MAX;
                end else begin
                    q = (num * Q_FULL) / span;
                    if (q >= Q_FULL) begin
                        c.blue = LEVEL_MAX;
                    end else begin
                        ramp = q[7:0];
                        case (ramp_seg_e'(q[9:8]))
                            SEG_RED_YELLOW: begin
                                c.red = LEVEL_MAX;
                                c.green = ramp;
                            end
                            SEG_YELLOW_GREEN: begin
                                c.red = LEVEL_MAX - ramp;
                                c.green = LEVEL_MAX;
                            end
                            SEG_GREEN_CYAN: begin
                                c.green = LEVEL_MAX;
                                c.blue = ramp;
                            end
                            default: begin
                                c.green = LEVEL_MAX - ramp;
                                c.blue = LEVEL_MAX;
                            end
                        endcase
                    end
                end
            end
        end
        return c;
    endfunction

    function automatic logic signed [31:0] pick_sample(int qi);
        longint lo;
        longint hi;
        longint f;
        longint v;
        if (qi >= NUM_QUANTITIES)
            qi = 0;
        lo = scale_low[qi];
        hi = scale_high[qi];
        case ($urandom_range(7))
            0: v = longint'($signed($urandom()));
            1: v = $urandom_range(1) ? lo : hi;
            2: v = $urandom_range(1) ? VAL_MIN : VAL_MAX;
            default: begin
                // spread over the scale, overshooting it by an eighth on each side
                f = longint'($urandom_range(32'(FRAC_ONE + FRAC_ONE / 4))) - FRAC_ONE / 8;
                v = lo + (((hi - lo) * f) >>> FRAC_BITS);
            end
        endcase
        if (v > VAL_MAX)
            v = VAL_MAX;
        if (v < VAL_MIN)
            v = VAL_MIN;
        return v[31:0];
    endfunction

    task automatic queue_sample(input int qi, input longint v);
        vjc_pkg::in_item_t item;
        item.quantity_index = 2'(qi);
        item.sample_value = v[31:0];
        pending_samples.push_back(item);
    endtask

    task automatic write_reg(input int idx, input longint value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= 3'(idx);
        cfg_data <= value[31:0];
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic end_writes();
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic randomize_scales();
        longint lo;
        longint hi;
        longint t;
        for (int qi = 0; qi < NUM_QUANTITIES; qi++) begin
            case ($urandom_range(5))
                0: begin
                    lo = longint'($signed($urandom()));
                    hi = longint'($signed($urandom()));
                end
                1: begin
                    lo = VAL_MIN;
                    hi = VAL_MAX;
                end
                2: begin
                    lo = longint'($signed($urandom()));
                    hi = lo;
                end
                default: begin
                    lo = longint'($signed($urandom())) >>> 6;
                    hi = lo + longint'($urandom_range(1 << 24)) + 1;
                end
            endcase
            if ($urandom_range(3) == 0) begin
                t = lo;
                lo = hi;
                hi = t;
            end
            write_reg(REG_LOW_Q0 + REG_STRIDE * qi, lo);
            write_reg(REG_HIGH_Q0 + REG_STRIDE * qi, hi);
        end
        if ($urandom_range(3) == 0)
            write_reg(REG_SPARE, longint'($urandom()));
        write_reg(vjc_pkg::REG_KNOWN_MASK, ($urandom_range(9) < 7) ? 7 : $urandom_range(7));
        end_writes();
    endtask

    task automatic drain();
        while (pending_samples.size() != 0 || s_valid || expected_colors.size() != 0)
            @(posedge aclk);
        repeat (PIPE_LATENCY + 3) @(posedge aclk);
    endtask

    task automatic random_items(input int count);
        int qi;
        for (int k = 0; k < count; k++) begin
            qi = ($urandom_range(9) == 0) ? 3 : $urandom_range(NUM_QUANTITIES - 1);
            queue_sample(qi, pick_sample(qi));
        end
    endtask

    // sender
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_taken) begin
            if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_data <= pending_samples.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold-off on request
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_request && !hold_taken) begin
            m_ready <= 1'b0;
            hold_taken <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor and scoreboard
    always @(posedge aclk) begin
        s_taken <= s_valid && s_ready;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index < vjc_pkg::REG_KNOWN_MASK) begin
                    if (cfg_index[0])
                        scale_high[cfg_index / REG_STRIDE] = cfg_data;
                    else
                        scale_low[cfg_index / REG_STRIDE] = cfg_data;
                end else if (cfg_index == vjc_pkg::REG_KNOWN_MASK) begin
                    known_mask = cfg_data[2:0];
                end
            end
            if (m_valid && m_ready) begin
                if (expected_colors.size() == 0) begin
                    $error("color item with no sample pending: %p", m_data);
                    fail_count++;
                end else begin
                    want_color = expected_colors.pop_front();
                    if (m_data.red !== want_color.red) begin
                        $error("red: expected %0d, got %0d", want_color.red, m_data.red);
                        fail_count++;
                    end
                    if (m_data.green !== want_color.green) begin
                        $error("green: expected %0d, got %0d", want_color.green, m_data.green);
                        fail_count++;
                    end
                    if (m_data.blue !== want_color.blue) begin
                        $error("blue: expected %0d, got %0d", want_color.blue, m_data.blue);
                        fail_count++;
                    end
                    if (m_data.color_valid !== want_color.color_valid) begin
                        $error("color_valid: expected %0d, got %0d",
                               want_color.color_valid, m_data.color_valid);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready)
                expected_colors.push_back(predict_color(s_data));
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("value_to_jet_color test failed");
            $finish;
        end
    end

    initial begin
        for (int qi = 0; qi < NUM_QUANTITIES; qi++) begin
            scale_low[qi] = -ONE;
            scale_high[qi] = ONE;
        end
        known_mask = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset state: no quantity known
        queue_sample(0, 0);
        queue_sample(1, ONE);
        queue_sample(2, -ONE);
        queue_sample(3, 0);
        drain();

        // reset bounds of -1.0 .. +1.0
        write_reg(vjc_pkg::REG_KNOWN_MASK, 7);
        end_writes();
        queue_sample(0, -ONE);
        queue_sample(0, ONE);
        queue_sample(1, 0);
        queue_sample(1, ONE / 2);
        queue_sample(2, ONE - 1);
        queue_sample(2, -ONE + 1);
        queue_sample(0, 100000);
        queue_sample(0, VAL_MIN);
        queue_sample(1, VAL_MAX);
        queue_sample(3, 0);
        drain();

        // full-width, reversed and zero-width scales; spare index ignored
        write_reg(REG_LOW_Q0, VAL_MIN);
        write_reg(REG_HIGH_Q0, VAL_MAX);
        write_reg(REG_LOW_Q1, 10 * ONE);
        write_reg(REG_HIGH_Q1, -10 * ONE);
        write_reg(REG_LOW_Q2, 5 * ONE);
        write_reg(REG_HIGH_Q2, 5 * ONE);
        write_reg(REG_SPARE, 0);
        end_writes();
        queue_sample(0, VAL_MIN);
        queue_sample(0, VAL_MAX);
        queue_sample(0, 0);
        queue_sample(1, 0);
        queue_sample(1, 10 * ONE);
        queue_sample(1, -10 * ONE);
        queue_sample(2, 5 * ONE);
        drain();

        write_reg(vjc_pkg::REG_KNOWN_MASK, 2);
        end_writes();
        queue_sample(0, 0);
        queue_sample(1, ONE);
        queue_sample(2, 0);
        drain();

        randomize_scales();
        random_items(PHASE_ITEMS);
        drain();

        send_idle_pct = 70;
        recv_idle_pct = 24;
        randomize_scales();
        random_items(PHASE_ITEMS);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        randomize_scales();
        random_items(PHASE_ITEMS);
        hold_request = 1'b1;
        drain();

        if (expected_colors.size() != 0) begin
            $error("%0d colors never arrived", expected_colors.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("value_to_jet_color test passed");
        else
            $display("value_to_jet_color test failed");
        $finish;
    end

endmodule
